// ===== hdl/xmodem_crc_block_receiver_top_macros.svh =====
// ----------------------------------------------------------------------------
// XMODEM-CRC block receiver assertion macros
// Immediate-consequence and next-cycle checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef XMODEM_CRC_BLOCK_RECEIVER_TOP_MACROS_SVH
`define XMODEM_CRC_BLOCK_RECEIVER_TOP_MACROS_SVH

// check cons in the same cycle as ante
`define XCRC_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xcrc same-cycle check failed");

// check cons in the cycle after ante
`define XCRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xcrc next-cycle check failed");

`endif

// ===== hdl/xcrc_pkg.sv =====
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver package
// Shared codes, byte values and the command word passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package xcrc_pkg;

    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_ACK  = 2'd1;
    localparam logic [1:0] REPLY_NAK  = 2'd2;

    localparam logic [1:0] STATUS_IDLE = 2'd0;
    localparam logic [1:0] STATUS_RECV = 2'd1;
    localparam logic [1:0] STATUS_DONE = 2'd2;
    localparam logic [1:0] STATUS_FAIL = 2'd3;

    localparam logic [7:0] BYTE_EOT = 8'h04;
    localparam logic [7:0] BYTE_CAN = 8'h18;
    localparam logic [7:0] BYTE_NAK = 8'h15;
    localparam logic [7:0] BYTE_C   = 8'h43;
    localparam logic [7:0] BYTE_END_NUM  = 8'hFF;
    localparam logic [7:0] BYTE_END_COMP = 8'h00;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic REG_FLASH_BASE = 1'b0;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic        burst;
        logic [1:0]  reply;
        logic [1:0]  status;
        logic [23:0] base;
    } xcrc_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/xcrc_queue.sv =====
// ----------------------------------------------------------------------------
// XMODEM-CRC command queue
// Short FIFO of command words between the byte front end and the result back end.
// ----------------------------------------------------------------------------
`default_nettype none

module xcrc_queue
    import xcrc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire xcrc_cmd_t push_cmd,
    output logic           full,
    input  wire logic      pop,
    output xcrc_cmd_t      pop_cmd,
    output logic           empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    xcrc_cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  do_push, do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/xcrc_front.sv =====
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver front end
// Accepts bytes, tracks link mode and frame position, runs the CRC, stores
// payload bytes and issues one command word per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module xcrc_front
    import xcrc_pkg::*;
#(
    parameter int BLOCK_BYTES = 128,
    parameter int POS_W       = $clog2(BLOCK_BYTES + 5)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [23:0]      flash_base,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [7:0]       rx_byte,
    output logic                  push,
    output xcrc_cmd_t             cmd,
    input  wire logic             q_full,
    input  wire logic             burst_done,
    output logic                  mem_we,
    output logic [POS_W-1:0]      mem_idx,
    output logic [7:0]            mem_data
);

    localparam int FRAME_LEN = BLOCK_BYTES + 5;

    typedef enum logic [3:0]
    {
        MODE_IDLE = 4'b0001,
        MODE_RECV = 4'b0010,
        MODE_DONE = 4'b0100,
        MODE_FAIL = 4'b1000
    } mode_t;

    mode_t             mode_reg, mode_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]        exp_reg, exp_next;
    logic [7:0]        hnum_reg, hnum_next;
    logic [7:0]        hcomp_reg, hcomp_next;
    logic [15:0]       rcheck_reg, rcheck_next;
    logic [15:0]       crc_reg, crc_next;
    logic              busy_reg, busy_next;
    logic              accept;
    logic              is_data;
    logic [7:0]        exp_m1;
    logic [31:0]       blk_off;
    logic [23:0]       blk_base;

    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        r = c ^ {d, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    function automatic logic [1:0] mode_status(input mode_t m);
        logic [1:0] s;
        case (m)
            MODE_IDLE: s = STATUS_IDLE;
            MODE_RECV: s = STATUS_RECV;
            MODE_DONE: s = STATUS_DONE;
            MODE_FAIL: s = STATUS_FAIL;
            default:   s = STATUS_IDLE;
        endcase
        return s;
    endfunction

    assign in_stall = q_full || busy_reg;
    assign accept   = in_valid && !in_stall;
    assign push     = accept;
    assign mem_idx  = pos_reg - POS_W'(3);
    assign mem_data = rx_byte;
    assign is_data  = (pos_reg >= POS_W'(3)) && (pos_reg < POS_W'(BLOCK_BYTES + 3));
    assign exp_m1   = exp_reg - 8'd1;
    assign blk_off  = 32'(exp_m1) * 32'(BLOCK_BYTES);
    assign blk_base = 24'(32'(flash_base) + blk_off);

    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        exp_next    = exp_reg;
        hnum_next   = hnum_reg;
        hcomp_next  = hcomp_reg;
        rcheck_next = rcheck_reg;
        crc_next    = crc_reg;
        busy_next   = busy_reg;
        mem_we      = 1'b0;
        cmd.burst   = 1'b0;
        cmd.reply   = REPLY_NONE;
        cmd.base    = '0;
        if (burst_done)
        begin
            busy_next = 1'b0;
        end
        if (accept)
        begin
            case (mode_reg)
                MODE_IDLE:
                begin
                    if (rx_byte == BYTE_NAK || rx_byte == BYTE_C)
                    begin
                        mode_next = MODE_RECV;
                        pos_next  = '0;
                        exp_next  = 8'd1;
                        crc_next  = '0;
                    end
                end
                MODE_RECV:
                begin
                    if (pos_reg == '0 && rx_byte == BYTE_EOT)
                    begin
                        mode_next = MODE_DONE;
                        cmd.reply = REPLY_ACK;
                    end
                    else if (pos_reg == '0 && rx_byte == BYTE_CAN)
                    begin
                        mode_next = MODE_FAIL;
                    end
                    else
                    begin
                        if (pos_reg == POS_W'(1))
                        begin
                            hnum_next = rx_byte;
                        end
                        else if (pos_reg == POS_W'(2))
                        begin
                            hcomp_next = rx_byte;
                        end
                        else if (is_data)
                        begin
                            mem_we   = 1'b1;
                            crc_next = crc16_byte(crc_reg, rx_byte);
                        end
                        else if (pos_reg >= POS_W'(BLOCK_BYTES + 3))
                        begin
                            rcheck_next = {rcheck_reg[7:0], rx_byte};
                        end
                        if (pos_reg != POS_W'(FRAME_LEN - 1))
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                        else
                        begin
                            pos_next = '0;
                            crc_next = '0;
                            if (hnum_reg == exp_reg && hcomp_reg == ~exp_reg)
                            begin
                                if (rcheck_next == crc_reg)
                                begin
                                    cmd.burst = 1'b1;
                                    cmd.reply = REPLY_ACK;
                                    cmd.base  = blk_base;
                                    exp_next  = exp_reg + 8'd1;
                                    busy_next = 1'b1;
                                end
                                else
                                begin
                                    cmd.reply = REPLY_NAK;
                                end
                            end
                            else if (hnum_reg == BYTE_END_NUM && hcomp_reg == BYTE_END_COMP)
                            begin
                                mode_next = MODE_DONE;
                                cmd.reply = REPLY_ACK;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        cmd.status = mode_status(mode_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            exp_reg    <= 8'd1;
            hnum_reg   <= '0;
            hcomp_reg  <= '0;
            rcheck_reg <= '0;
            crc_reg    <= '0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            exp_reg    <= exp_next;
            hnum_reg   <= hnum_next;
            hcomp_reg  <= hcomp_next;
            rcheck_reg <= rcheck_next;
            crc_reg    <= crc_next;
            busy_reg   <= busy_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/xcrc_back.sv =====
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver back end
// Holds the payload memory, drains command words and drives the result
// output register, expanding a good frame into flash write words and an ACK.
// ----------------------------------------------------------------------------
`default_nettype none

module xcrc_back
    import xcrc_pkg::*;
#(
    parameter int BLOCK_BYTES = 128,
    parameter int POS_W       = $clog2(BLOCK_BYTES + 5)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire xcrc_cmd_t         q_cmd,
    output logic                   pop,
    input  wire logic              mem_we,
    input  wire logic [POS_W-1:0]  mem_idx,
    input  wire logic [7:0]        mem_data,
    output logic                   burst_done,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             reply_code,
    output logic                   write_valid,
    output logic [23:0]            write_address,
    output logic [63:0]            write_data,
    output logic [1:0]             link_status,
    output logic                   last_result
);

    localparam int WORDS   = BLOCK_BYTES / 8;
    localparam int WORD_AW = $clog2(WORDS);

    typedef enum logic [3:0]
    {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_ACK  = 4'b1000
    } state_t;

    logic [63:0]         mem [WORDS];
    logic [63:0]         rdata_reg;

    state_t              state_reg, state_next;
    logic [WORD_AW-1:0]  word_reg, word_next;
    logic [23:0]         base_reg, base_next;
    logic [1:0]          status_reg, status_next;
    logic                ovalid_reg, ovalid_next;
    logic [1:0]          reply_reg, reply_next;
    logic                wv_reg, wv_next;
    logic [23:0]         addr_reg, addr_next;
    logic [63:0]         data_reg, data_next;
    logic [1:0]          ostat_reg, ostat_next;
    logic                last_reg, last_next;
    logic                out_free;

    assign out_free      = !ovalid_reg || !out_stall;
    assign out_valid     = ovalid_reg;
    assign reply_code    = reply_reg;
    assign write_valid   = wv_reg;
    assign write_address = addr_reg;
    assign write_data    = data_reg;
    assign link_status   = ostat_reg;
    assign last_result   = last_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_idx[3 +: WORD_AW]][8 * mem_idx[2:0] +: 8] <= mem_data;
        end
        rdata_reg <= mem[word_reg];
    end

    always_comb
    begin
        state_next  = state_reg;
        word_next   = word_reg;
        base_next   = base_reg;
        status_next = status_reg;
        ovalid_next = ovalid_reg && out_stall;
        reply_next  = reply_reg;
        wv_next     = wv_reg;
        addr_next   = addr_reg;
        data_next   = data_reg;
        ostat_next  = ostat_reg;
        last_next   = last_reg;
        pop         = 1'b0;
        burst_done  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    pop = 1'b1;
                    if (q_cmd.burst)
                    begin
                        base_next   = q_cmd.base;
                        status_next = q_cmd.status;
                        word_next   = '0;
                        state_next  = ST_LOAD;
                    end
                    else
                    begin
                        ovalid_next = 1'b1;
                        reply_next  = q_cmd.reply;
                        wv_next     = 1'b0;
                        addr_next   = '0;
                        data_next   = '0;
                        ostat_next  = q_cmd.status;
                        last_next   = 1'b1;
                    end
                end
            end
            ST_LOAD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    reply_next  = REPLY_NONE;
                    wv_next     = 1'b1;
                    addr_next   = 24'(base_reg + (24'(word_reg) << 3));
                    data_next   = rdata_reg;
                    ostat_next  = status_reg;
                    last_next   = 1'b0;
                    if (word_reg == WORD_AW'(WORDS - 1))
                    begin
                        state_next = ST_ACK;
                    end
                    else
                    begin
                        word_next  = word_reg + 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    reply_next  = REPLY_ACK;
                    wv_next     = 1'b0;
                    addr_next   = '0;
                    data_next   = '0;
                    ostat_next  = status_reg;
                    last_next   = 1'b1;
                    burst_done  = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            word_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            word_reg   <= word_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        status_reg <= status_next;
        reply_reg  <= reply_next;
        wv_reg     <= wv_next;
        addr_reg   <= addr_next;
        data_reg   <= data_next;
        ostat_reg  <= ostat_next;
        last_reg   <= last_next;
    end

endmodule

`default_nettype wire

// ===== hdl/xmodem_crc_block_receiver_top.sv =====
// ----------------------------------------------------------------------------
// XMODEM-CRC block receiver
// Receives XMODEM-CRC frames byte by byte, checks number and CRC-16, and
// produces flash write words and ACK/NAK replies.
//
// Channel   Direction  Handshake               Word
// rx        in         in_valid / in_stall     rx_byte
// result    out        out_valid / out_stall   reply_code .. last_result
// config    in         APB psel/penable        flash_base_address at 0x0
//
// One byte per cycle while no flash burst is in progress and the queue is not full.
// After a good frame's last byte the input stalls until the burst ends with
// its ACK: each write word takes one payload memory read
// and one output load.
// Every byte yields one command word through a two-entry queue.
// Reset clears all control state; no clearing pass is needed.
// A stalled output holds its word; the queue lets bytes continue meanwhile until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xmodem_crc_block_receiver_top_macros.svh"

module xmodem_crc_block_receiver_top
    import xcrc_pkg::*;
#(
    parameter int BLOCK_BYTES = 128
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic [7:0]   rx_byte,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [1:0]        reply_code,
    output logic              write_valid,
    output logic [23:0]       write_address,
    output logic [63:0]       write_data,
    output logic [1:0]        link_status,
    output logic              last_result
);

    localparam int POS_W = $clog2(BLOCK_BYTES + 5);

    logic [23:0]       flash_base_reg, flash_base_next;
    logic              cfg_write;
    logic              q_push, q_full, q_pop, q_empty;
    xcrc_cmd_t         push_cmd, pop_cmd;
    logic              burst_done;
    logic              mem_we;
    logic [POS_W-1:0]  mem_idx;
    logic [7:0]        mem_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_FLASH_BASE) ? {8'h00, flash_base_reg} : '0;

    always_comb
    begin
        flash_base_next = flash_base_reg;
        if (cfg_write && paddr[2] == REG_FLASH_BASE)
        begin
            flash_base_next = pwdata[23:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_base_reg <= '0;
        end
        else
        begin
            flash_base_reg <= flash_base_next;
        end
    end

    xcrc_front #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .POS_W       (POS_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .flash_base (flash_base_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .push       (q_push),
        .cmd        (push_cmd),
        .q_full     (q_full),
        .burst_done (burst_done),
        .mem_we     (mem_we),
        .mem_idx    (mem_idx),
        .mem_data   (mem_data)
    );

    xcrc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    xcrc_back #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .POS_W       (POS_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_cmd         (pop_cmd),
        .pop           (q_pop),
        .mem_we        (mem_we),
        .mem_idx       (mem_idx),
        .mem_data      (mem_data),
        .burst_done    (burst_done),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .reply_code    (reply_code),
        .write_valid   (write_valid),
        .write_address (write_address),
        .write_data    (write_data),
        .link_status   (link_status),
        .last_result   (last_result)
    );

    `XCRC_ASSERT_IMPLIES(a_write_fields, out_valid && write_valid, reply_code == REPLY_NONE && !last_result && link_status == STATUS_RECV)
    `XCRC_ASSERT_IMPLIES(a_plain_fields, out_valid && !write_valid, write_address == '0 && write_data == '0 && last_result)
    `XCRC_ASSERT_IMPLIES(a_burst_holds_input, out_valid && !last_result, in_stall)
    `XCRC_ASSERT_NEXT(a_stall_holds, out_valid && out_stall, out_valid && $stable(write_data) && $stable(last_result))

endmodule

`default_nettype wire
